// File: src/rtb_pkg.sv
// Package for the reload timer bank: sizes, command codes and the queue entry type.
// No dependencies.
package rtb_pkg;
  localparam int NumTimers = 16;
  localparam int IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW = 32;
  localparam logic [CntW-1:0] NeverCount = '1;

  typedef enum logic [2:0] {
    ModeTick   = 3'd0,
    ModeStart  = 3'd1,
    ModeStop   = 3'd2,
    ModePause  = 3'd3,
    ModeResume = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [3:0]      idx;
    logic [CntW-1:0] count;
    logic [CntW-1:0] interval;
  } cmd_t;
endpackage

// File: src/reload_timer_bank_unit.sv
// Top level of the reload timer bank: front queue plus back execution unit.
// Depends on rtb_pkg, rtb_front and rtb_back.
//
// Usage: present a request on mode_i, timer_index_i, start_count_i and
// reload_interval_i with start high; it is taken at a clock edge where busy
// is low. Requests enter a two-entry queue; busy rises only when it is full.
// Start, stop, pause and resume are executed by the back end as they are
// dequeued. A tick walks all NumTimers timers, one per cycle, and holds the
// back end for the walk, plus a flush step when the last timer expires after
// an earlier one; the timer register file is read at one index per cycle.
// Each expiry appears on expired_timer_o with expired_valid_o high for
// exactly one cycle, in ascending index order, delayed until the next expiry
// or the end of the walk; last_expiry_o marks the final expiry of a tick. A
// tick with no expiry produces nothing. The receiver cannot stall results.
// Reset sets every count and reload to never, all timers stopped and paused,
// and empties the queue.
module reload_timer_bank_unit import rtb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] start_count_i,
  input  logic [31:0] reload_interval_i,
  output logic        expired_valid_o,
  output logic [3:0]  expired_timer_o,
  output logic        last_expiry_o
);
  logic q_valid, q_pop;
  cmd_t q_data;

  rtb_front u_front (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .timer_index_i,
    .start_count_i, .reload_interval_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  rtb_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .expired_valid_o, .expired_timer_o, .last_expiry_o
  );
endmodule

// File: src/rtb_front.sv
// Front end: accepts requests, drops invalid ones and queues the rest.
// Depends on rtb_pkg.
module rtb_front import rtb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] start_count_i,
  input  logic [31:0] reload_interval_i,
  output logic        q_valid_o,
  output cmd_t        q_data_o,
  input  logic        q_pop_i
);
  cmd_t       mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push, keep;

  assign busy = cnt_q[1];
  assign keep = (mode_i == ModeTick) ||
                ((mode_i <= ModeResume) && ({1'b0, timer_index_i} < 5'(NumTimers)));
  assign push = start && !busy && keep;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_data_o = mem_q[rp_q];
  assign cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (q_pop_i) rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{mode: mode_e'(mode_i), idx: timer_index_i,
                       count: start_count_i, interval: reload_interval_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("push lost");
endmodule

// File: src/rtb_back.sv
// Back end: timer state, command execution and the tick walk over all timers.
// Depends on rtb_pkg.
module rtb_back import rtb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_data_i,
  output logic        q_pop_o,
  output logic        expired_valid_o,
  output logic [3:0]  expired_timer_o,
  output logic        last_expiry_o
);
  logic [CntW-1:0] cnt_q [NumTimers];
  logic [CntW-1:0] rel_q [NumTimers];
  logic [NumTimers-1:0] act_q, pau_q;
  logic            walk_q;
  logic            flush_q;
  logic [IdxW-1:0] pos_q;
  logic            pend_q;
  logic [3:0]      pend_idx_q;
  logic            fire, lastpos, walk_start;
  logic [CntW-1:0] dec;
  logic [IdxW-1:0] ci;

  assign ci = q_data_i.idx[IdxW-1:0];
  assign walk_start = !walk_q && !flush_q && q_valid_i && q_data_i.mode == ModeTick;
  assign q_pop_o = !walk_q && !flush_q && q_valid_i;
  assign dec = cnt_q[pos_q] - 1'b1;
  assign fire = walk_q && act_q[pos_q] && !pau_q[pos_q] &&
                cnt_q[pos_q] != NeverCount && dec == '0;
  assign lastpos = pos_q == IdxW'(NumTimers - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTimers; i++) begin
        cnt_q[i] <= NeverCount;
        rel_q[i] <= NeverCount;
      end
      act_q <= '0;
      pau_q <= '1;
      walk_q <= 1'b0;
      flush_q <= 1'b0;
      pos_q <= '0;
      pend_q <= 1'b0;
      pend_idx_q <= '0;
      expired_valid_o <= 1'b0;
      expired_timer_o <= '0;
      last_expiry_o <= 1'b0;
    end else begin
      expired_valid_o <= 1'b0;
      if (walk_q) begin
        if (act_q[pos_q] && !pau_q[pos_q] && cnt_q[pos_q] != NeverCount) begin
          cnt_q[pos_q] <= fire ? rel_q[pos_q] : dec;
        end
        if (pend_q && (fire || lastpos)) begin
          expired_valid_o <= 1'b1;
          expired_timer_o <= pend_idx_q;
          last_expiry_o <= lastpos && !fire;
        end
        if (fire) begin
          pend_q <= 1'b1;
          pend_idx_q <= 4'(pos_q);
        end
        if (lastpos) begin
          walk_q <= 1'b0;
          pos_q <= '0;
          if (fire && pend_q) begin
            flush_q <= 1'b1;
          end else if (fire) begin
            pend_q <= 1'b0;
            expired_valid_o <= 1'b1;
            expired_timer_o <= 4'(pos_q);
            last_expiry_o <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end else if (flush_q) begin
        flush_q <= 1'b0;
        pend_q <= 1'b0;
        expired_valid_o <= 1'b1;
        expired_timer_o <= pend_idx_q;
        last_expiry_o <= 1'b1;
      end else if (q_valid_i) begin
        unique case (q_data_i.mode)
          ModeTick: walk_q <= 1'b1;
          ModeStart: begin
            cnt_q[ci] <= q_data_i.count;
            rel_q[ci] <= (q_data_i.interval != '0) ? q_data_i.interval : NeverCount;
            pau_q[ci] <= 1'b0;
            act_q[ci] <= 1'b1;
          end
          ModeStop: act_q[ci] <= 1'b0;
          ModePause: pau_q[ci] <= 1'b1;
          ModeResume: pau_q[ci] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) walk_start |=> walk_q)
    else $error("tick did not start walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (walk_q || flush_q) |-> !q_pop_o)
    else $error("pop during walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (expired_valid_o && !last_expiry_o) |-> (walk_q || flush_q))
    else $error("non-final expiry outside walk");
endmodule

// File: tb/tb.sv
// Self-checking testbench for reload_timer_bank_unit: random and directed requests
// checked against a behavioral timer bank held in a small scoreboard class.
// Depends on rtb_pkg and the reload_timer_bank_unit RTL.
module tb;
  import rtb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0] timer;
    logic       last;
  } expiry_t;

  class timer_scoreboard;
    logic [CntW-1:0] count_q[NumTimers];
    logic [CntW-1:0] reload_q[NumTimers];
    bit              running[NumTimers];
    bit              held[NumTimers];
    expiry_t         pending[$];
    int              mismatches;

    function void clear();
      for (int i = 0; i < NumTimers; i++) begin
        count_q[i] = NeverCount;
        reload_q[i] = NeverCount;
        running[i] = 0;
        held[i] = 1;
      end
      mismatches = 0;
    endfunction

    function void note_request(logic [2:0] mode, logic [3:0] idx,
                               logic [31:0] cnt, logic [31:0] ival);
      expiry_t e;
      int first;
      first = pending.size();
      case (mode)
        ModeTick: begin
          for (int i = 0; i < NumTimers; i++) begin
            if (running[i] && !held[i] && count_q[i] != NeverCount) begin
              count_q[i] = count_q[i] - 32'd1;
              if (count_q[i] == 0) begin
                count_q[i] = reload_q[i];
                e.timer = 4'(i);
                e.last = 0;
                pending.push_back(e);
              end
            end
          end
          if (pending.size() > first) pending[pending.size()-1].last = 1;
        end
        ModeStart: begin
          count_q[idx] = cnt;
          reload_q[idx] = (ival != 0) ? ival : NeverCount;
          held[idx] = 0;
          running[idx] = 1;
        end
        ModeStop: running[idx] = 0;
        ModePause: held[idx] = 1;
        ModeResume: held[idx] = 0;
        default: ;
      endcase
    endfunction

    function void check_expiry(logic [3:0] timer, logic last);
      expiry_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected expiry: timer %0d last %0b", timer, last);
        return;
      end
      e = pending.pop_front();
      if (e.timer !== timer || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Expiry mismatch: expected timer %0d last %0b, got timer %0d last %0b",
                   e.timer, e.last, timer, last);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  mode_i = ModeTick;
  logic [3:0]  timer_index_i = 0;
  logic [31:0] start_count_i = 0;
  logic [31:0] reload_interval_i = 0;
  logic        expired_valid_o;
  logic [3:0]  expired_timer_o;
  logic        last_expiry_o;

  timer_scoreboard sb;
  int idle_pct;

  reload_timer_bank_unit dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .timer_index_i, .start_count_i,
    .reload_interval_i, .expired_valid_o, .expired_timer_o, .last_expiry_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && expired_valid_o) sb.check_expiry(expired_timer_o, last_expiry_o);
    if (rst_ni && start && !busy)
      sb.note_request(mode_i, timer_index_i, start_count_i, reload_interval_i);
  end

  task automatic send_request(logic [2:0] mode, logic [3:0] idx,
                              logic [31:0] cnt, logic [31:0] ival);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk_i);
    end
    start <= 1;
    mode_i <= mode;
    timer_index_i <= idx;
    start_count_i <= cnt;
    reload_interval_i <= ival;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_expiries();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic random_request();
    int r;
    logic [31:0] cnt;
    logic [31:0] ival;
    r = $urandom_range(99);
    cnt = $urandom_range(6);
    ival = $urandom_range(5);
    if ($urandom_range(9) == 0) cnt = $urandom;
    if ($urandom_range(9) == 0) ival = $urandom;
    if ($urandom_range(19) == 0) cnt = NeverCount;
    if (r < 50) send_request(ModeTick, 4'($urandom), $urandom, $urandom);
    else if (r < 72) send_request(ModeStart, 4'($urandom), cnt, ival);
    else if (r < 80) send_request(ModeStop, 4'($urandom), $urandom, $urandom);
    else if (r < 88) send_request(ModePause, 4'($urandom), $urandom, $urandom);
    else if (r < 96) send_request(ModeResume, 4'($urandom), $urandom, $urandom);
    else send_request(3'($urandom_range(7, 5)), 4'($urandom), $urandom, $urandom);
  endtask

  initial begin
    sb = new();
    sb.clear();
    idle_pct = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    send_request(ModeTick, 0, 0, 0);
    send_request(ModeResume, 3, 0, 0);
    send_request(ModeTick, 0, 0, 0);
    for (int i = 0; i < NumTimers; i++) send_request(ModeStart, 4'(i), 1, 1);
    send_request(ModeTick, 15, '1, '1);
    send_request(ModeStart, 0, 0, 0);
    send_request(ModeStart, 1, 2, 0);
    send_request(ModeStart, 2, '1, 1);
    send_request(ModeStart, 15, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(ModeStop, 4, 0, 0);
    send_request(ModePause, 5, 0, 0);
    send_request(ModeTick, 0, 0, 0);
    send_request(ModeResume, 4, 0, 0);
    send_request(ModeResume, 5, 0, 0);
    send_request(3'd7, 6, '1, '1);
    send_request(ModeTick, 0, 0, 0);
    drain_expiries();

    idle_pct = 28;
    repeat (70) random_request();
    drain_expiries();
    idle_pct = 85;
    repeat (60) random_request();
    idle_pct = 0;
    repeat (70) random_request();
    drain_expiries();

    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// File: filelist.f
src/rtb_pkg.sv
src/rtb_front.sv
src/rtb_back.sv
src/reload_timer_bank_unit.sv
tb/tb.sv
